// ===== hdl/flpm_pkg.sv =====
// ----------------------------------------------------------------------------
// flpm_pkg
// Shared types and constants for the four-level page mapper.
// ----------------------------------------------------------------------------
package flpm_pkg;

    // Table geometry
    localparam int ENTRY_BITS = 9;      // 512 entries per table
    localparam int PN_BITS    = 40;     // page number, address bits 51:12
    localparam int ENTRY_W    = 64;
    localparam int PHYS_W     = 52;
    localparam int VIRT_W     = 48;
    localparam int CFG_W      = 52;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST_PAGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGE_COUNT = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_MAPPED         = 2'd0;
    localparam logic [1:0] ST_ALREADY_MAPPED = 2'd1;
    localparam logic [1:0] ST_POOL_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE_WINDOW = 2'd3;

    // Entry flags
    localparam logic [2:0] FLAGS_ROOT  = 3'b011;  // present, writable
    localparam logic [2:0] FLAGS_LOWER = 3'b111;  // present, writable, user

    // Reset values
    localparam logic [6:0] POOL_FIRST_RESET = 7'd1;
    localparam logic [6:0] POOL_COUNT_RESET = 7'd63;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ZERO,
        S_LINK,
        S_DONE
    } state_t;

endpackage

// ===== hdl/flpm_ram.sv =====
// ----------------------------------------------------------------------------
// flpm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flpm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/flpm_alu.sv =====
// ----------------------------------------------------------------------------
// flpm_alu
// Shared page-number adder: window offset of a pointer, or page number of a
// store page, modulo 2^40.
// ----------------------------------------------------------------------------
module flpm_alu (
    input  flpm_pkg::alu_op_t op,
    input  logic [39:0]       a,
    input  logic [39:0]       b,
    output logic [39:0]       y
);

    import flpm_pkg::*;

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

// ===== hdl/four_level_page_mapper.sv =====
// ----------------------------------------------------------------------------
// four_level_page_mapper
// Maps one 4 KiB virtual page per request into an on-chip four-level table
// store, allocating and zeroing missing tables from a bump pool.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis word: phys_page_addr and virt_addr. m_axis word: status,
//   tables_added and pool_pages_left of that request, one result per word.
//   The cfg port writes window_base, root_page, pool_first_page (also loads
//   the pool pointer) and pool_page_count (also loads the free count); write
//   it only while no request is in flight.
//   Walk, acceptance to result: a root outside the window goes straight to
//   the result; otherwise each level is read (address, then registered
//   entry check), and each new table is zeroed entry by entry and then
//   linked, at most three new tables per request. All store traffic goes
//   through one RAM write port and one read port, so one request is in
//   work at a time; s_axis_tready is high only between requests.
//   A finished result waits in the output register while the next request
//   is accepted; the walk stalls at its end if the previous result has not
//   yet been taken.
//   Reset: after rst_n rises the store is cleared one entry a cycle,
//   every entry of all STORE_PAGES pages, with s_axis_tready low.
// ----------------------------------------------------------------------------
module four_level_page_mapper #(
    parameter int STORE_PAGES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request: phys_page_addr[51:0], virt_addr[99:52], zero pad
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [103:0]                 s_axis_tdata,
    // result: status[1:0], tables_added[3:2], pool_pages_left[10:4], zero pad
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [flpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [flpm_pkg::CFG_W-1:0]   cfg_wdata
);

    import flpm_pkg::*;

    localparam int PAGE_BITS = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int DEPTH     = STORE_PAGES * (1 << ENTRY_BITS);
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam logic [ADDR_BITS-1:0]  CLEAR_LAST = ADDR_BITS'(DEPTH - 1);
    localparam logic [12:0]           PAGES_13   = 13'(STORE_PAGES);
    localparam logic [PN_BITS-1:0]    PAGES_PN   = PN_BITS'(STORE_PAGES);
    localparam logic [ENTRY_BITS-1:0] ZERO_LAST  = '1;

    // state and registers
    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [PN_BITS-1:0]    base_pn_reg, base_pn_next;
    logic [5:0]            root_reg, root_next;
    logic [6:0]            pool_next_reg, pool_next_next;
    logic [6:0]            left_reg, left_next;
    logic [PHYS_W-1:0]     phys_reg, phys_next;
    logic [VIRT_W-1:0]     va_reg, va_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [1:0]            added_reg, added_next;
    logic [1:0]            status_reg, status_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [PAGE_BITS-1:0]  alloc_reg, alloc_next;
    logic [ENTRY_BITS-1:0] zcnt_reg, zcnt_next;
    logic                  res_valid_reg, res_valid_next;
    logic [10:0]           res_reg, res_next;

    // memory and shared adder signals
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [ENTRY_W-1:0]    mem_rdata;
    alu_op_t               alu_op;
    logic [PN_BITS-1:0]    alu_a;
    logic [PN_BITS-1:0]    alu_b;
    logic [PN_BITS-1:0]    alu_y;
    logic [ENTRY_BITS-1:0] idx;
    logic [ADDR_BITS-1:0]  slot;
    logic [12:0]           root_13;
    logic [12:0]           pool_13;
    logic                  in_fire;

    flpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    flpm_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // table index of the current level
    always_comb
    begin
        case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign slot      = {page_reg, idx};
    assign mem_raddr = slot;
    assign root_13   = 13'(root_reg);
    assign pool_13   = 13'(pool_next_reg);
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg};

    // shared adder: offset of a read pointer, or page number of a new table
    always_comb
    begin
        if (state_reg == S_LINK)
        begin
            alu_op = ALU_ADD;
            alu_a  = base_pn_reg;
            alu_b  = PN_BITS'(alloc_reg);
        end
        else
        begin
            alu_op = ALU_SUB;
            alu_a  = mem_rdata[51:12];
            alu_b  = base_pn_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            base_pn_reg   <= '0;
            root_reg      <= '0;
            pool_next_reg <= POOL_FIRST_RESET;
            left_reg      <= POOL_COUNT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            base_pn_reg   <= base_pn_next;
            root_reg      <= root_next;
            pool_next_reg <= pool_next_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        phys_reg   <= phys_next;
        va_reg     <= va_next;
        lvl_reg    <= lvl_next;
        added_reg  <= added_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        alloc_reg  <= alloc_next;
        zcnt_reg   <= zcnt_next;
        res_reg    <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        base_pn_next   = base_pn_reg;
        root_next      = root_reg;
        pool_next_next = pool_next_reg;
        left_next      = left_reg;
        res_valid_next = res_valid_reg;
        phys_next      = phys_reg;
        va_next        = va_reg;
        lvl_next       = lvl_reg;
        added_next     = added_reg;
        status_next    = status_reg;
        page_next      = page_reg;
        alloc_next     = alloc_reg;
        zcnt_next      = zcnt_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot;
        mem_wdata      = '0;

        // result taken downstream
        if (res_valid_reg && m_axis_tready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLEAR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    phys_next  = s_axis_tdata[51:0];
                    va_next    = s_axis_tdata[99:52];
                    lvl_next   = 2'd0;
                    added_next = 2'd0;
                    page_next  = root_13[PAGE_BITS-1:0];
                    if (root_13 >= PAGES_13)
                    begin
                        status_next = ST_OUTSIDE_WINDOW;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = ST_MAPPED;
                        state_next  = S_READ;
                    end
                end
            end

            // address presented; entry arrives next cycle
            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (lvl_reg == 2'd3)
                begin
                    // leaf
                    if (mem_rdata[0])
                    begin
                        status_next = ST_ALREADY_MAPPED;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {12'd0, phys_reg[51:12], 9'd0, FLAGS_LOWER};
                    end
                    state_next = S_DONE;
                end
                else if (!mem_rdata[0])
                begin
                    // missing table: take a pool page
                    if (left_reg == 7'd0 || pool_13 >= PAGES_13)
                    begin
                        status_next = ST_POOL_EXHAUSTED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        alloc_next     = pool_13[PAGE_BITS-1:0];
                        pool_next_next = pool_next_reg + 1'b1;
                        left_next      = left_reg - 1'b1;
                        zcnt_next      = '0;
                        state_next     = S_ZERO;
                    end
                end
                else if (alu_y < PAGES_PN)
                begin
                    // present pointer inside the window
                    page_next  = alu_y[PAGE_BITS-1:0];
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    status_next = ST_OUTSIDE_WINDOW;
                    state_next  = S_DONE;
                end
            end

            // zero the fresh table one entry a cycle
            S_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = {alloc_reg, zcnt_reg};
                zcnt_next = zcnt_reg + 1'b1;
                if (zcnt_reg == ZERO_LAST)
                begin
                    state_next = S_LINK;
                end
            end

            // link the fresh table into the current level
            S_LINK:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {12'd0, alu_y, 9'd0,
                              (lvl_reg == 2'd0) ? FLAGS_ROOT : FLAGS_LOWER};
                added_next = added_reg + 1'b1;
                page_next  = alloc_reg;
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_READ;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!res_valid_reg || m_axis_tready)
                begin
                    res_next       = {left_reg, added_reg, status_reg};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes, taken in any state
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_BASE:     base_pn_next   = cfg_wdata[51:12];
                CFG_ROOT_PAGE:       root_next      = cfg_wdata[5:0];
                CFG_POOL_FIRST_PAGE: pool_next_next = {1'b0, cfg_wdata[5:0]};
                CFG_POOL_PAGE_COUNT: left_next      = cfg_wdata[6:0];
                default:             root_next      = root_reg;
            endcase
        end
    end

endmodule
